FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property at every rising edge outside reset
`define PST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pst assertion failed");
// same check, also active during reset
`define PST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pst assertion failed");
`else
`define PST_ASSERT(lbl, clk, rstn, prop)
`define PST_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/pst_pkg.sv
`timescale 1ns / 1ps
package pst_pkg;

  localparam int KEYWORD_MAX_DEF = 9;
  localparam int LINE_BITS_DEF   = 16;
  localparam int LENGTH_BITS_DEF = 8;
  localparam int Q_DEPTH         = 4;
  localparam int KW_COUNT        = 14;
  localparam int KW_CHARS        = 9;

  typedef enum logic [3:0] {
    K_ADD     = 4'd0,
    K_MUL     = 4'd1,
    K_DELIM   = 4'd2,
    K_REL     = 4'd3,
    K_ASSIGN  = 4'd4,
    K_INT     = 4'd5,
    K_REAL    = 4'd6,
    K_IDENT   = 4'd7,
    K_KEYWORD = 4'd8,
    K_EOF     = 4'd9,
    K_ERROR   = 4'd10
  } kind_t;

  localparam logic [7:0] ERR_COMMENT = 8'd0;
  localparam logic [7:0] ERR_POINT   = 8'd1;
  localparam logic [7:0] ERR_CHAR    = 8'd2;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // keyword text, left aligned, padded with blanks
  localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
    "program  ", "var      ", "integer  ", "real     ", "boolean  ",
    "procedure", "begin    ", "end      ", "if       ", "then     ",
    "else     ", "while    ", "do       ", "not      "
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd7, 4'd3, 4'd7, 4'd4, 4'd7, 4'd9, 4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd3
  };

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sub;
    logic [15:0] line;
    logic [7:0]  len;
  } result_t;

  // all results caused by one input beat
  typedef struct packed {
    logic [1:0]      cnt;
    result_t [2:0]   res;
  } bundle_t;

endpackage

FILE: rtl/core/pst_if.sv
`timescale 1ns / 1ps
interface pst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;
  modport source (output valid, char_code, end_of_input, input ready);
  modport sink (input valid, char_code, end_of_input, output ready);
endinterface

interface pst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  sub_code;
  logic [15:0] line_number;
  logic [7:0]  lexeme_length;
  logic        last_of_run;
  modport source (output valid, token_kind, sub_code, line_number, lexeme_length,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, sub_code, line_number, lexeme_length,
                last_of_run, output ready);
endinterface

FILE: rtl/core/pascal_subset_tokenizer_top.sv
`timescale 1ns / 1ps
// Pascal subset tokenizer.
// in_chan takes one source byte per beat (char_code), or an end-of-file mark
// (end_of_input high). out_chan gives tokens: kind, sub code, line, length,
// and last_of_run on the last token caused by one input beat.
// A byte is scanned in the cycle it is accepted: one input beat per cycle
// while the queue is not full. Tokens it completes go as one group into a
// four-entry queue, and the output stage sends one token per cycle while
// the receiver is ready; each token passes the queue and a hold register.
// A beat gives up to three tokens, so a long run of such beats is limited
// by the one-token-per-cycle output stage; in_chan.ready drops only when the
// queue is full.
// When the receiver stalls, tokens wait in the queue and input keeps flowing
// until the queue fills.
// Reset (rst_n low, synchronous) empties the queue, sets the scanner between
// tokens and the line counter to one.
module pascal_subset_tokenizer_top
  import pst_pkg::*;
#(
  parameter int KEYWORD_MAX = KEYWORD_MAX_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pst_in_if.sink    in_chan,
  pst_out_if.source out_chan
);

  logic    fire, push, pop, not_empty, full;
  bundle_t wbundle, rbundle;

  assign in_chan.ready = !full;
  assign fire = in_chan.valid && in_chan.ready;

  pst_front #(
    .KEYWORD_MAX (KEYWORD_MAX),
    .LINE_BITS   (LINE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .char_code    (in_chan.char_code),
    .end_of_input (in_chan.end_of_input),
    .push         (push),
    .bundle       (wbundle)
  );

  pst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (wbundle),
    .pop       (pop),
    .rdata     (rbundle),
    .not_empty (not_empty),
    .full      (full)
  );

  pst_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (rbundle),
    .q_not_empty (not_empty),
    .q_pop       (pop),
    .out_ch      (out_chan)
  );

endmodule

FILE: rtl/core/pst_front.sv
`timescale 1ns / 1ps
module pst_front
  import pst_pkg::*;
#(
  parameter int KEYWORD_MAX = KEYWORD_MAX_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output logic       push,
  output bundle_t    bundle
);

  typedef enum logic [2:0] {
    S_IDLE, S_COMMENT, S_REL, S_COLON, S_INT, S_POINT, S_REAL, S_IDENT
  } state_t;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

  state_t                 state_r, state_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [7:0]             first_r, first_nxt;
  logic [7:0]             word_r [KEYWORD_MAX];
  logic                   we;
  logic [7:0]             wdata;
  logic [LENGTH_BITS-1:0] waddr;

  logic       is_digit, is_alpha, is_space, is_idch;
  logic       do_close, do_idle, line_inc;
  logic [1:0] cp_n, n;
  result_t    cp0, cp1, si, eof_r;
  logic       si_v;
  logic [15:0] line16;
  logic [7:0]  len8;
  logic        kw_hit;
  logic [7:0]  kw_idx;
  logic        same;
  logic [LENGTH_BITS-1:0] len_grow;

  // character classes
  assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_alpha = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                    ((char_code >= 8'h41) && (char_code <= 8'h5A));
  assign is_space = (char_code == 8'h20) || ((char_code >= 8'd9) && (char_code <= 8'd13));
  assign is_idch  = is_alpha || is_digit || (char_code == CH_UNDER);
  assign len_grow = (len_r != LEN_MAX) ? len_r + 1'b1 : len_r;

  // saturated views for the result fields
  always_comb begin
    if (LINE_BITS > 16 && line_r > LINE_BITS'(16'hFFFF)) line16 = 16'hFFFF;
    else line16 = 16'(line_r);
    if (LENGTH_BITS > 8 && len_r > LENGTH_BITS'(8'hFF)) len8 = 8'hFF;
    else len8 = 8'(len_r);
  end

  // keyword lookup on the stored identifier
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 8'd0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      same = (len_r == LENGTH_BITS'(KW_LEN[k]));
      for (int i = 0; i < KW_CHARS; i++) begin
        if (i < int'(KW_LEN[k]) && word_r[i] != KW_TEXT[k][(KW_CHARS-1-i)*8 +: 8])
          same = 1'b0;
      end
      if (same) begin
        kw_hit = 1'b1;
        kw_idx = 8'(k);
      end
    end
  end

  // scanner next state and results
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    line_inc  = 1'b0;
    we        = 1'b0;
    wdata     = char_code;
    waddr     = len_r;
    do_close  = 1'b0;
    do_idle   = 1'b0;
    cp_n      = 2'd0;
    cp0       = '{kind: K_EOF, sub: 8'd0, line: line16, len: 8'd0};
    cp1       = cp0;
    si_v      = 1'b0;
    si        = cp0;
    eof_r     = cp0;

    if (end_of_input) begin
      do_close = 1'b1;
    end else begin
      unique case (state_r)
        S_COMMENT: begin
          if (char_code == CH_NL) line_inc = 1'b1;
          if (char_code == CH_RBRACE) state_nxt = S_IDLE;
        end
        S_REL: begin
          if (char_code == CH_EQUAL || (char_code == CH_GT && first_r == CH_LT)) begin
            cp_n = 2'd1;
            cp0  = '{kind: K_REL, sub: first_r + char_code, line: line16, len: 8'd2};
            state_nxt = S_IDLE;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        S_COLON: begin
          if (char_code == CH_EQUAL) begin
            cp_n = 2'd1;
            cp0  = '{kind: K_ASSIGN, sub: CH_COLON, line: line16, len: 8'd2};
            state_nxt = S_IDLE;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        S_INT: begin
          if (is_digit) len_nxt = len_grow;
          else if (char_code == CH_POINT) begin
            len_nxt   = len_grow;
            state_nxt = S_POINT;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        S_POINT: begin
          if (is_digit) begin
            len_nxt   = len_grow;
            state_nxt = S_REAL;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        S_REAL: begin
          if (is_digit) len_nxt = len_grow;
          else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        S_IDENT: begin
          if (is_idch) begin
            if (len_r < LENGTH_BITS'(KEYWORD_MAX)) we = 1'b1;
            len_nxt = len_grow;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        S_IDLE: do_idle = 1'b1;
        default: do_idle = 1'b1;
      endcase
    end

    // report the pending token
    if (do_close) begin
      state_nxt = S_IDLE;
      unique case (state_r)
        S_COMMENT: begin
          cp_n = 2'd1;
          cp0  = '{kind: K_ERROR, sub: ERR_COMMENT, line: line16, len: 8'd0};
        end
        S_REL: begin
          cp_n = 2'd1;
          cp0  = '{kind: K_REL, sub: first_r, line: line16, len: 8'd1};
        end
        S_COLON: begin
          cp_n = 2'd1;
          cp0  = '{kind: K_DELIM, sub: CH_COLON, line: line16, len: 8'd1};
        end
        S_INT: begin
          cp_n = 2'd1;
          cp0  = '{kind: K_INT, sub: 8'd0, line: line16, len: len8};
        end
        S_POINT: begin
          cp_n = 2'd2;
          cp0  = '{kind: K_ERROR, sub: ERR_POINT, line: line16, len: 8'd0};
          cp1  = '{kind: K_REAL, sub: 8'd0, line: line16, len: len8};
        end
        S_REAL: begin
          cp_n = 2'd1;
          cp0  = '{kind: K_REAL, sub: 8'd0, line: line16, len: len8};
        end
        S_IDENT: begin
          cp_n = 2'd1;
          if (kw_hit) cp0 = '{kind: K_KEYWORD, sub: kw_idx, line: line16, len: len8};
          else cp0 = '{kind: K_IDENT, sub: 8'd0, line: line16, len: len8};
        end
        default: cp_n = 2'd0;
      endcase
    end

    // scan the byte from idle
    if (do_idle) begin
      state_nxt = S_IDLE;
      if (is_space) begin
        if (char_code == CH_NL) line_inc = 1'b1;
      end else if (char_code == CH_LBRACE) begin
        state_nxt = S_COMMENT;
      end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
        si_v = 1'b1;
        si   = '{kind: K_ADD, sub: char_code, line: line16, len: 8'd1};
      end else if (char_code == CH_STAR || char_code == CH_SLASH) begin
        si_v = 1'b1;
        si   = '{kind: K_MUL, sub: char_code, line: line16, len: 8'd1};
      end else if (char_code == CH_SEMI || char_code == CH_POINT ||
                   char_code == CH_LPAREN || char_code == CH_RPAREN) begin
        si_v = 1'b1;
        si   = '{kind: K_DELIM, sub: char_code, line: line16, len: 8'd1};
      end else if (char_code == CH_LT || char_code == CH_GT) begin
        first_nxt = char_code;
        state_nxt = S_REL;
      end else if (char_code == CH_EQUAL) begin
        si_v = 1'b1;
        si   = '{kind: K_REL, sub: char_code, line: line16, len: 8'd1};
      end else if (char_code == CH_COLON) begin
        state_nxt = S_COLON;
      end else if (is_digit) begin
        len_nxt   = LENGTH_BITS'(1);
        state_nxt = S_INT;
      end else if (is_alpha) begin
        we        = 1'b1;
        waddr     = '0;
        len_nxt   = LENGTH_BITS'(1);
        state_nxt = S_IDENT;
      end else begin
        si_v = 1'b1;
        si   = '{kind: K_ERROR, sub: ERR_CHAR, line: line16, len: 8'd1};
      end
    end

    line_nxt = (line_inc && line_r != LINE_MAX) ? line_r + 1'b1 : line_r;
  end

  // pack results in order
  always_comb begin
    bundle.res = {cp0, cp0, cp0};
    bundle.res[0] = cp0;
    bundle.res[1] = cp1;
    n = cp_n;
    if (si_v) begin
      bundle.res[n] = si;
      n = n + 2'd1;
    end
    if (end_of_input) begin
      bundle.res[n] = eof_r;
      n = n + 2'd1;
    end
    bundle.cnt = n;
    push = fire && (n != 2'd0);
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      line_r  <= LINE_BITS'(1);
      len_r   <= '0;
      first_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
      len_r   <= len_nxt;
      first_r <= first_nxt;
    end
  end

  // identifier text store
  always_ff @(posedge clk) begin
    if (fire && we) word_r[waddr[$clog2(KEYWORD_MAX)-1:0]] <= wdata;
  end

endmodule

FILE: rtl/core/pst_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pst_queue
  import pst_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wdata,
  input  logic    pop,
  output bundle_t rdata,
  output logic    not_empty,
  output logic    full
);

  localparam int PW = $clog2(Q_DEPTH);

  bundle_t         mem [Q_DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [PW:0]     cnt_r;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (PW+1)'(Q_DEPTH));
  assign rdata     = mem[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // bundle storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wdata;
  end

  `PST_ASSERT(a_no_overflow, clk, rst_n, push |-> (!full || pop))
  `PST_ASSERT(a_no_underflow, clk, rst_n, pop |-> not_empty)
  `PST_ASSERT(a_count_range, clk, rst_n, cnt_r <= (PW+1)'(Q_DEPTH))
  `PST_ASSERT(a_count_step, clk, rst_n,
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))

endmodule

FILE: rtl/core/pst_back.sv
`timescale 1ns / 1ps
module pst_back
  import pst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bundle_t   q_data,
  input  logic      q_not_empty,
  output logic      q_pop,
  pst_out_if.source out_ch
);

  bundle_t    hold_r;
  logic       hold_v_r;
  logic [1:0] idx_r;
  logic       last, take;
  result_t    cur;

  assign cur  = hold_r.res[idx_r];
  assign last = (idx_r == hold_r.cnt - 2'd1);
  assign take = out_ch.valid && out_ch.ready;
  assign q_pop = q_not_empty && (!hold_v_r || (take && last));

  assign out_ch.valid         = hold_v_r;
  assign out_ch.token_kind    = cur.kind;
  assign out_ch.sub_code      = cur.sub;
  assign out_ch.line_number   = cur.line;
  assign out_ch.lexeme_length = cur.len;
  assign out_ch.last_of_run   = last;

  // walk the tokens of the held bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      idx_r    <= '0;
    end else if (q_pop) begin
      hold_v_r <= 1'b1;
      idx_r    <= '0;
    end else if (take) begin
      if (last) hold_v_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) hold_r <= q_data;
  end

endmodule
